[hw/rtl/srsw_pkg.sv]
// Shared types, codes and defaults for the selective-repeat sender window.
package srsw_pkg;

  parameter int WINDOW_DEF       = 8;
  parameter int SEQ_BITS_DEF     = 16;
  parameter int PAYLOAD_BITS_DEF = 64;

  // Fixed port widths of the request and result fields
  parameter int SEQ_PORT_W = 16;
  parameter int PAY_PORT_W = 64;
  parameter int OP_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOD,
    ST_READ,
    ST_SLIDE,
    ST_RESP
  } st_e;

  typedef struct packed {
    logic                  accepted;
    logic                  tx_valid;
    logic [SEQ_PORT_W-1:0] tx_seq;
    logic [PAY_PORT_W-1:0] tx_payload;
    logic                  timer_start;
    logic                  timer_stop;
    logic [SEQ_PORT_W-1:0] timer_seq;
  } res_t;

endpackage

[hw/rtl/srsw_slot_mod.sv]
// Slot remainder unit: sequence number modulo the slot count by reciprocal multiply.
module srsw_slot_mod #(
  parameter int SEQ_BITS = srsw_pkg::SEQ_BITS_DEF,
  parameter int SLOTS    = 2 * srsw_pkg::WINDOW_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [SEQ_BITS-1:0]        value_i,
  output logic                       done_o,
  output logic [$clog2(SLOTS)-1:0]   rem_o
);

  localparam int SlotW = $clog2(SLOTS);
  localparam int ProdW = 2 * SEQ_BITS;
  localparam int WideW = SEQ_BITS + 8;
  // Scaled reciprocal of the slot count; the quotient estimate is low by at most one
  localparam longint unsigned Recip = (64'd1 << SEQ_BITS) / SLOTS;
  localparam logic [SEQ_BITS-1:0] RecipW = SEQ_BITS'(Recip);

  logic [SEQ_BITS-1:0] val_q, val_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [SlotW-1:0]    rem_q, rem_d;
  logic                mul_q, mul_d;
  logic                sub_q, sub_d;
  logic                done_q, done_d;
  logic [SEQ_BITS-1:0] quot_est;
  logic [SlotW-1:0]    rem_fix;

  assign quot_est = prod_q[ProdW-1:SEQ_BITS];

  // Remainder from the quotient estimate; one compare-subtract fixes it up
  always_comb begin
    logic [WideW-1:0] r;
    r = WideW'(val_q) - WideW'(quot_est) * WideW'(SLOTS);
    if (r >= WideW'(SLOTS)) begin
      r = r - WideW'(SLOTS);
    end
    rem_fix = r[SlotW-1:0];
  end

  // Load the value, then multiply, then reduce
  always_comb begin
    val_d  = val_q;
    prod_d = prod_q;
    rem_d  = rem_q;
    mul_d  = 1'b0;
    sub_d  = 1'b0;
    done_d = 1'b0;
    if (start_i) begin
      val_d = value_i;
      mul_d = 1'b1;
    end else if (mul_q) begin
      prod_d = ProdW'(val_q) * ProdW'(RecipW);
      sub_d  = 1'b1;
    end else if (sub_q) begin
      rem_d  = rem_fix;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= mul_d;
      sub_q  <= sub_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/srsw_pay_mem.sv]
// Payload store: one write port, one registered read port.
module srsw_pay_mem #(
  parameter int DEPTH = 2 * srsw_pkg::WINDOW_DEF,
  parameter int DW    = srsw_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);
  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/selective_repeat_sender_window_top.sv]
// Selective-repeat ARQ sender window: sequencer, window state and result register.
//
// Request channel (in_valid_i / in_stall_o) carries one operation: send a new
// payload, an acknowledgement (with its checksum verdict) or a timer expiry.
// Every request yields exactly one result on the result channel
// (out_valid_o / out_stall_i): transmit and timer commands plus the window
// state after the operation.
// Sequencer steps, from the accepting edge to the edge that loads the result:
//   send, ignored ack, unknown op : decode, then response
//   ack of the window base        : decode, one slide step per slot slid past, response
//   timeout                       : decode, slot remainder by reciprocal
//                                   multiply, payload read, response
// A new request can be taken in the cycle after the result is loaded.
// in_stall_o is high whenever the sequencer is busy. A finished result sits in
// the output register while the next request is taken; if the receiver keeps
// stalling, the sequencer holds in its response state until the register frees.
// Reset clears base, next, the full flag and every acked mark; the payload
// store is not cleared, so a timeout for a slot never sent returns junk.
module selective_repeat_sender_window_top #(
  parameter int WINDOW       = srsw_pkg::WINDOW_DEF,
  parameter int SEQ_BITS     = srsw_pkg::SEQ_BITS_DEF,
  parameter int PAYLOAD_BITS = srsw_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [srsw_pkg::OP_W-1:0]       operation_i,
  input  logic [srsw_pkg::PAY_PORT_W-1:0] payload_i,
  input  logic [srsw_pkg::SEQ_PORT_W-1:0] seq_number_i,
  input  logic                            checksum_ok_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            send_accepted_o,
  output logic                            tx_valid_o,
  output logic [srsw_pkg::SEQ_PORT_W-1:0] tx_seq_o,
  output logic [srsw_pkg::PAY_PORT_W-1:0] tx_payload_o,
  output logic                            timer_start_o,
  output logic                            timer_stop_o,
  output logic [srsw_pkg::SEQ_PORT_W-1:0] timer_seq_o,
  output logic                            window_full_o,
  output logic [srsw_pkg::SEQ_PORT_W-1:0] window_base_o
);
  import srsw_pkg::*;

  localparam int Slots   = 2 * WINDOW;
  localparam int SlotW   = $clog2(Slots);
  localparam int SeqWide = (SEQ_BITS > SEQ_PORT_W) ? SEQ_BITS : SEQ_PORT_W;

  st_e state_q, state_d;

  // Captured request
  logic [OP_W-1:0]         op_q, op_d;
  logic [SEQ_BITS-1:0]     seq_q, seq_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic                    ck_q, ck_d;

  // Window state; slot indexes track base and next incrementally
  logic [SEQ_BITS-1:0] base_q, base_d, next_q, next_d;
  logic [SlotW-1:0]    base_slot_q, base_slot_d, next_slot_q, next_slot_d;
  logic                full_q, full_d;
  logic [Slots-1:0]    acked_q, acked_d;

  // Result under construction and the output register
  res_t             res_q, res_d;
  res_t             out_res_q;
  logic             out_full_q;
  logic [SEQ_PORT_W-1:0] out_base_q;
  logic             out_valid_q, out_valid_d;

  logic in_acc, out_take, out_load;

  // Port-width conversions of sequence numbers
  logic [SeqWide-1:0]    seq_in_wide, seq_q_wide, next_q_wide, base_q_wide;
  logic [SEQ_BITS-1:0]   seq_in;
  logic [SEQ_PORT_W-1:0] seq_q_port, next_q_port, base_q_port;

  logic [SEQ_BITS-1:0] outstanding, ack_off, next_inc, base_inc;
  logic                send_ok, in_win, slide_go;
  logic [SlotW:0]      slot_sum;
  logic [SlotW-1:0]    ack_slot, next_slot_inc, base_slot_inc;

  // Remainder unit and payload store hookups
  logic                    mod_start, mod_done;
  logic [SlotW-1:0]        mod_rem;
  logic                    mem_we, mem_re;
  logic [PAYLOAD_BITS-1:0] mem_rdata;

  assign seq_in_wide = SeqWide'(seq_number_i);
  assign seq_in      = seq_in_wide[SEQ_BITS-1:0];
  assign seq_q_wide  = SeqWide'(seq_q);
  assign next_q_wide = SeqWide'(next_q);
  assign base_q_wide = SeqWide'(base_q);
  assign seq_q_port  = seq_q_wide[SEQ_PORT_W-1:0];
  assign next_q_port = next_q_wide[SEQ_PORT_W-1:0];
  assign base_q_port = base_q_wide[SEQ_PORT_W-1:0];

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_take = out_valid_q && !out_stall_i;
  assign out_load = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  assign outstanding = next_q - base_q;
  assign ack_off     = seq_q - base_q;
  assign send_ok     = !full_q && (outstanding < SEQ_BITS'(WINDOW));
  assign in_win      = ck_q && (ack_off < outstanding);
  assign slide_go    = (base_q != next_q) && acked_q[base_slot_q];

  // Slot of an in-window ack: past the sequence wrap the number itself is the
  // slot (it is below the window size), otherwise base slot plus distance.
  assign slot_sum = {1'b0, base_slot_q} + (SlotW+1)'(ack_off[SlotW-1:0]);
  always_comb begin
    logic [SlotW:0] t;
    t = (slot_sum >= (SlotW+1)'(Slots)) ? (slot_sum - (SlotW+1)'(Slots)) : slot_sum;
    ack_slot = (seq_q < base_q) ? seq_q[SlotW-1:0] : t[SlotW-1:0];
  end

  // Advance a sequence number and its slot; the slot restarts at the sequence wrap and after the last slot
  assign next_inc = next_q + 1'b1;
  assign base_inc = base_q + 1'b1;
  assign next_slot_inc = ((next_inc == '0) || (next_slot_q == SlotW'(Slots - 1))) ?
                         '0 : next_slot_q + 1'b1;
  assign base_slot_inc = ((base_inc == '0) || (base_slot_q == SlotW'(Slots - 1))) ?
                         '0 : base_slot_q + 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (op_q)
          OP_SEND:    state_d = ST_RESP;
          OP_ACK:     state_d = (in_win && (ack_off == '0)) ? ST_SLIDE : ST_RESP;
          OP_TIMEOUT: state_d = ST_MOD;
          default:    state_d = ST_RESP;
        endcase
      end
      ST_MOD: begin
        if (mod_done) state_d = ST_READ;
      end
      ST_READ:  state_d = ST_RESP;
      ST_SLIDE: begin
        if (!slide_go) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates per state
  always_comb begin
    op_d        = op_q;
    seq_d       = seq_q;
    pay_d       = pay_q;
    ck_d        = ck_q;
    base_d      = base_q;
    base_slot_d = base_slot_q;
    next_d      = next_q;
    next_slot_d = next_slot_q;
    full_d      = full_q;
    acked_d     = acked_q;
    res_d       = res_q;
    mod_start   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d      = operation_i;
          seq_d     = seq_in;
          pay_d     = payload_i[PAYLOAD_BITS-1:0];
          ck_d      = checksum_ok_i;
          res_d     = '0;
          // Kick off the slot remainder at once for a timeout
          mod_start = (operation_i == OP_TIMEOUT);
        end
      end
      ST_DECODE: begin
        case (op_q)
          OP_SEND: begin
            if (send_ok) begin
              mem_we               = 1'b1;
              acked_d[next_slot_q] = 1'b0;
              res_d.accepted       = 1'b1;
              res_d.tx_valid       = 1'b1;
              res_d.tx_seq         = next_q_port;
              res_d.tx_payload     = PAY_PORT_W'(pay_q);
              res_d.timer_start    = 1'b1;
              res_d.timer_seq      = next_q_port;
              next_d               = next_inc;
              next_slot_d          = next_slot_inc;
              if (outstanding + 1'b1 == SEQ_BITS'(WINDOW)) full_d = 1'b1;
            end
          end
          OP_ACK: begin
            if (in_win) begin
              if (ack_off == '0) begin
                res_d.timer_stop  = 1'b1;
                res_d.timer_seq   = seq_q_port;
                acked_d[ack_slot] = 1'b1;
                full_d            = 1'b0;
              end else if (!acked_q[ack_slot]) begin
                res_d.timer_stop  = 1'b1;
                res_d.timer_seq   = seq_q_port;
                acked_d[ack_slot] = 1'b1;
              end
            end
          end
          OP_TIMEOUT: begin
            res_d.tx_valid    = 1'b1;
            res_d.tx_seq      = seq_q_port;
            res_d.timer_start = 1'b1;
            res_d.timer_seq   = seq_q_port;
          end
          default: begin
          end
        endcase
      end
      ST_MOD: begin
        mem_re = mod_done;
      end
      ST_READ: begin
        res_d.tx_payload = PAY_PORT_W'(mem_rdata);
      end
      ST_SLIDE: begin
        // Slide one acked slot per cycle; stop at next or the first hole
        if (slide_go) begin
          acked_d[base_slot_q] = 1'b0;
          base_d               = base_inc;
          base_slot_d          = base_slot_inc;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_take ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      base_q      <= '0;
      base_slot_q <= '0;
      next_q      <= '0;
      next_slot_q <= '0;
      full_q      <= 1'b0;
      acked_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      base_q      <= base_d;
      base_slot_q <= base_slot_d;
      next_q      <= next_d;
      next_slot_q <= next_slot_d;
      full_q      <= full_d;
      acked_q     <= acked_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
    pay_q <= pay_d;
    ck_q  <= ck_d;
    res_q <= res_d;
    if (out_load) begin
      out_res_q  <= res_q;
      out_full_q <= full_q;
      out_base_q <= base_q_port;
    end
  end

  srsw_slot_mod #(
    .SEQ_BITS (SEQ_BITS),
    .SLOTS    (Slots)
  ) u_slot_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (seq_in),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  srsw_pay_mem #(
    .DEPTH (Slots),
    .DW    (PAYLOAD_BITS)
  ) u_pay_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (next_slot_q),
    .wdata_i (pay_q),
    .re_i    (mem_re),
    .raddr_i (mod_rem),
    .rdata_o (mem_rdata)
  );

  // Port drive
  always_comb begin
    in_stall_o      = (state_q != ST_IDLE);
    out_valid_o     = out_valid_q;
    send_accepted_o = out_res_q.accepted;
    tx_valid_o      = out_res_q.tx_valid;
    tx_seq_o        = out_res_q.tx_seq;
    tx_payload_o    = out_res_q.tx_payload;
    timer_start_o   = out_res_q.timer_start;
    timer_stop_o    = out_res_q.timer_stop;
    timer_seq_o     = out_res_q.timer_seq;
    window_full_o   = out_full_q;
    window_base_o   = out_base_q;
  end

endmodule

[sim/selective_repeat_sender_window_top_tb.sv]
// Self-checking testbench for the selective-repeat ARQ sender window.
module selective_repeat_sender_window_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srsw_pkg::*;

  localparam int WINDOW       = WINDOW_DEF;
  localparam int SEQ_BITS     = SEQ_BITS_DEF;
  localparam int PAYLOAD_BITS = PAYLOAD_BITS_DEF;
  localparam int SLOTS        = 2 * WINDOW;

  localparam logic [SEQ_PORT_W-1:0] SEQ_MASK = SEQ_PORT_W'((33'd1 << SEQ_BITS) - 33'd1);
  localparam logic [PAY_PORT_W-1:0] PAY_MASK =
    PAY_PORT_W'((65'd1 << PAYLOAD_BITS) - 65'd1);

  // Operation code that the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_REQUESTS = 730;
  localparam int CALM_FIRST      = 300;  // first random request of the no-idle stretch
  localparam int CALM_LAST       = 420;
  localparam int IDLE_PCT        = 29;
  localparam int MAX_REPORTS     = 10;
  // Longest request: ack of the base sliding a whole window, plus the
  // result register turnaround; drain a bit more than that.
  localparam int DRAIN_CYCLES    = 3 * (WINDOW + 8);
  localparam int CYCLE_LIMIT     = 400000;

  // One result of the block, in port order
  typedef struct packed {
    logic                  send_accepted;
    logic                  tx_valid;
    logic [SEQ_PORT_W-1:0] tx_seq;
    logic [PAY_PORT_W-1:0] tx_payload;
    logic                  timer_start;
    logic                  timer_stop;
    logic [SEQ_PORT_W-1:0] timer_seq;
    logic                  window_full;
    logic [SEQ_PORT_W-1:0] window_base;
  } window_result_t;

  // Mirror of the sender window: predicts one result per accepted request
  // and checks results in order against those predictions.
  class sender_window_checker;
    logic [SEQ_PORT_W-1:0] base_seq;
    logic [SEQ_PORT_W-1:0] next_seq;
    logic                  full_flag;
    logic                  acked [SLOTS];
    logic [PAY_PORT_W-1:0] slot_payload [SLOTS];
    bit                    slot_written [SLOTS];
    window_result_t        expected_window_results [$];
    int mismatches;
    int results_seen;
    int sends_taken;
    int sends_refused;
    int timers_stopped;
    int slides;
    int resends;

    function new();
      base_seq  = '0;
      next_seq  = '0;
      full_flag = 1'b0;
      foreach (acked[i]) begin
        acked[i]        = 1'b0;
        slot_payload[i] = '0;
        slot_written[i] = 1'b0;
      end
      mismatches     = 0;
      results_seen   = 0;
      sends_taken    = 0;
      sends_refused  = 0;
      timers_stopped = 0;
      slides         = 0;
      resends        = 0;
    endfunction

    function int slot_of(logic [SEQ_PORT_W-1:0] s);
      return int'(s) % SLOTS;
    endfunction

    function logic [SEQ_PORT_W-1:0] outstanding();
      return (next_seq - base_seq) & SEQ_MASK;
    endfunction

    function bit any_written();
      foreach (slot_written[i]) begin
        if (slot_written[i]) begin
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function window_result_t predict_window_step(logic [OP_W-1:0] op,
                                                 logic [PAY_PORT_W-1:0] pay,
                                                 logic [SEQ_PORT_W-1:0] seq_in,
                                                 logic ck);
      window_result_t        r;
      logic [SEQ_PORT_W-1:0] seq;
      logic [SEQ_PORT_W-1:0] ack_dist;
      logic [SEQ_PORT_W-1:0] in_flight;
      int                    s;
      r         = '0;
      seq       = seq_in & SEQ_MASK;
      in_flight = outstanding();
      case (op)
        OP_SEND: begin
          if (!full_flag && in_flight < WINDOW) begin
            s               = slot_of(next_seq);
            slot_payload[s] = pay & PAY_MASK;
            slot_written[s] = 1'b1;
            acked[s]        = 1'b0;
            r.send_accepted = 1'b1;
            r.tx_valid      = 1'b1;
            r.tx_seq        = next_seq;
            r.tx_payload    = pay & PAY_MASK;
            r.timer_start   = 1'b1;
            r.timer_seq     = next_seq;
            next_seq        = (next_seq + 1'b1) & SEQ_MASK;
            if (outstanding() == WINDOW) begin
              full_flag = 1'b1;
            end
            sends_taken++;
          end else begin
            sends_refused++;
          end
        end
        OP_ACK: begin
          ack_dist = (seq - base_seq) & SEQ_MASK;
          if (ck && ack_dist < in_flight) begin
            s = slot_of(seq);
            if (ack_dist == 0) begin
              // Base acked: reopen the window and slide over the acked slots up to the first hole
              r.timer_stop = 1'b1;
              r.timer_seq  = seq;
              acked[s]     = 1'b1;
              full_flag    = 1'b0;
              while (base_seq != next_seq && acked[slot_of(base_seq)]) begin
                acked[slot_of(base_seq)] = 1'b0;
                base_seq = (base_seq + 1'b1) & SEQ_MASK;
              end
              timers_stopped++;
              slides++;
            end else if (!acked[s]) begin
              r.timer_stop = 1'b1;
              r.timer_seq  = seq;
              acked[s]     = 1'b1;
              timers_stopped++;
            end
          end
        end
        OP_TIMEOUT: begin
          // Retransmit whatever the slot holds, no window check
          r.tx_valid    = 1'b1;
          r.tx_seq      = seq;
          r.tx_payload  = slot_payload[slot_of(seq)];
          r.timer_start = 1'b1;
          r.timer_seq   = seq;
          resends++;
        end
        default: begin
        end
      endcase
      r.window_full = full_flag;
      r.window_base = base_seq;
      return r;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [PAY_PORT_W-1:0] pay,
                               logic [SEQ_PORT_W-1:0] seq, logic ck);
      expected_window_results.push_back(predict_window_step(op, pay, seq, ck));
    endfunction

    function string describe(window_result_t r);
      return $sformatf({"acc=%0b txv=%0b txseq=%h txpay=%h tstart=%0b tstop=%0b",
                        " tseq=%h full=%0b base=%h"},
                       r.send_accepted, r.tx_valid, r.tx_seq, r.tx_payload, r.timer_start,
                       r.timer_stop, r.timer_seq, r.window_full, r.window_base);
    endfunction

    function void check_result(window_result_t got);
      window_result_t want;
      if (expected_window_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] result with no request pending: %s", $realtime, describe(got));
        end
        return;
      end
      want = expected_window_results.pop_front();
      results_seen++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] result %0d mismatch", $realtime, results_seen);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic [OP_W-1:0]       operation   = OP_SEND;
  logic [PAY_PORT_W-1:0] payload     = '0;
  logic [SEQ_PORT_W-1:0] seq_number  = '0;
  logic                  checksum_ok = 1'b0;
  logic                  out_stall   = 1'b0;
  // High during the stretch where neither side idles
  logic                  calm        = 1'b0;
  int                    cycle_count = 0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  send_accepted_o;
  logic                  tx_valid_o;
  logic [SEQ_PORT_W-1:0] tx_seq_o;
  logic [PAY_PORT_W-1:0] tx_payload_o;
  logic                  timer_start_o;
  logic                  timer_stop_o;
  logic [SEQ_PORT_W-1:0] timer_seq_o;
  logic                  window_full_o;
  logic [SEQ_PORT_W-1:0] window_base_o;
  window_result_t        observed;

  sender_window_checker  tracker;

  selective_repeat_sender_window_top #(
    .WINDOW      (WINDOW),
    .SEQ_BITS    (SEQ_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation),
    .payload_i      (payload),
    .seq_number_i   (seq_number),
    .checksum_ok_i  (checksum_ok),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .send_accepted_o(send_accepted_o),
    .tx_valid_o     (tx_valid_o),
    .tx_seq_o       (tx_seq_o),
    .tx_payload_o   (tx_payload_o),
    .timer_start_o  (timer_start_o),
    .timer_stop_o   (timer_stop_o),
    .timer_seq_o    (timer_seq_o),
    .window_full_o  (window_full_o),
    .window_base_o  (window_base_o)
  );

  assign observed = {send_accepted_o, tx_valid_o, tx_seq_o, tx_payload_o, timer_start_o,
                     timer_stop_o, timer_seq_o, window_full_o, window_base_o};

  initial begin
    forever #6 clk = ~clk;
  end

  // Count cycles for the watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: end a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still pending", cycle_count,
             tracker.expected_window_results.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: stall with a chance of 29 percent, never during the calm stretch.
  // Drive at the falling edge so the DUT sees a settled value at the rising edge.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Check every result taken at a rising edge; outputs are still the pre-edge values here
  always @(posedge clk) begin
    if (rst_n && out_valid_o && !out_stall) begin
      tracker.check_result(observed);
    end
  end

  // Insert random idle cycles before a request; skip them in the calm stretch.
  // Runs at a falling edge and returns at a falling edge.
  task automatic sender_gap();
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Present one request and hold it until accepted, then record it for prediction.
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [PAY_PORT_W-1:0] pay,
                               input logic [SEQ_PORT_W-1:0] seq, input logic ck);
    sender_gap();
    in_valid    <= 1'b1;
    operation   <= op;
    payload     <= pay;
    seq_number  <= seq;
    checksum_ok <= ck;
    do @(posedge clk); while (in_stall_o);
    tracker.note_request(op, pay, seq, ck);
    @(negedge clk);
  endtask

  // Hold off new requests until every pending result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.expected_window_results.size() != 0) @(negedge clk);
  endtask

  // Draw one random request. Most are well-formed traffic that keeps the
  // window moving: sends, acks of outstanding numbers (biased to the base so
  // the window slides), and timeouts of slots already written. The rest is
  // noise: bad checksums, stray acks and the unused operation code.
  task automatic random_request();
    int                    pick;
    int                    span;
    int                    slot;
    logic [SEQ_PORT_W-1:0] seq;
    logic [PAY_PORT_W-1:0] pay;
    pick = $urandom_range(0, 99);
    span = int'(tracker.outstanding());
    pay  = {$urandom, $urandom};
    if ($urandom_range(0, 19) == 0) begin
      pay = $urandom_range(0, 1) ? '1 : '0;
    end
    if (pick < 40) begin
      issue_request(OP_SEND, pay, SEQ_PORT_W'($urandom), 1'($urandom));
    end else if (pick < 75) begin
      if (span > 0) begin
        if ($urandom_range(0, 99) < 40) begin
          seq = tracker.base_seq;
        end else begin
          seq = (tracker.base_seq + SEQ_PORT_W'($urandom_range(0, span - 1))) & SEQ_MASK;
        end
      end else begin
        seq = SEQ_PORT_W'($urandom);
      end
      issue_request(OP_ACK, pay, seq, 1'b1);
    end else if (pick < 87 && tracker.any_written()) begin
      // Timeouts only name slots that a send has filled
      if (span > 0 && $urandom_range(0, 1)) begin
        seq = (tracker.base_seq + SEQ_PORT_W'($urandom_range(0, span - 1))) & SEQ_MASK;
      end else begin
        do slot = $urandom_range(0, SLOTS - 1); while (!tracker.slot_written[slot]);
        seq = SEQ_PORT_W'($urandom_range(0, (1 << SEQ_PORT_W) / SLOTS - 1) * SLOTS + slot);
      end
      issue_request(OP_TIMEOUT, pay, seq, 1'($urandom));
    end else if (pick < 92) begin
      issue_request(OP_ACK, pay, SEQ_PORT_W'($urandom), 1'b0);
    end else if (pick < 96) begin
      issue_request(OP_ACK, pay, SEQ_PORT_W'($urandom), 1'b1);
    end else begin
      issue_request(OP_UNUSED, pay, SEQ_PORT_W'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int n;
    tracker = new();
    // Hold reset, then release it at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests
    issue_request(OP_ACK, '0, 16'h0000, 1'b1);           // ack with nothing outstanding
    issue_request(OP_UNUSED, '1, 16'hFFFF, 1'b1);        // unused operation code
    issue_request(OP_SEND, '0, 16'h0000, 1'b0);          // fill the window
    issue_request(OP_SEND, '1, 16'hFFFF, 1'b1);
    issue_request(OP_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA, 1'b0);
    issue_request(OP_SEND, 64'h5555_5555_5555_5555, 16'h5555, 1'b1);
    issue_request(OP_SEND, 64'h8000_0000_0000_0000, 16'h0000, 1'b0);
    issue_request(OP_SEND, 64'h0000_0000_0000_0001, 16'h0000, 1'b0);
    issue_request(OP_SEND, {$urandom, $urandom}, 16'h0000, 1'b0);
    issue_request(OP_SEND, {$urandom, $urandom}, 16'h0000, 1'b0);
    issue_request(OP_SEND, {$urandom, $urandom}, 16'h0000, 1'b0); // refused, window full
    issue_request(OP_ACK, '0, 16'h0003, 1'b0);           // bad checksum
    issue_request(OP_ACK, '0, 16'h0008, 1'b1);           // ack of next, beyond the window
    issue_request(OP_ACK, '0, 16'h0002, 1'b1);           // ack inside the window
    issue_request(OP_ACK, '0, 16'h0002, 1'b1);           // same ack again
    issue_request(OP_ACK, '0, 16'h0001, 1'b1);
    issue_request(OP_TIMEOUT, '0, 16'h0000, 1'b0);       // resend slot 0
    issue_request(OP_TIMEOUT, '0, 16'hFFF7, 1'b1);       // high bits set, slot 7
    issue_request(OP_ACK, '0, 16'h0000, 1'b1);           // base acked, slide over 0..2
    issue_request(OP_ACK, '0, 16'hFFFF, 1'b1);           // far behind the base
    issue_request(OP_SEND, {$urandom, $urandom}, 16'h0000, 1'b1);
    issue_request(OP_ACK, '0, 16'h0005, 1'b1);
    issue_request(OP_UNUSED, '0, 16'h0000, 1'b0);

    wait_for_results();

    // Random requests, with a stretch where neither side idles
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      calm <= (n >= CALM_FIRST && n < CALM_LAST);
      if (n == 200 || $urandom_range(0, 199) == 0) begin
        wait_for_results();
      end
      random_request();
    end

    calm <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d sends taken, %0d refused, %0d timer stops",
             tracker.results_seen, tracker.sends_taken, tracker.sends_refused,
             tracker.timers_stopped);
    $display("Window slid on %0d base acks, %0d resends; final base %h, next %h",
             tracker.slides, tracker.resends, tracker.base_seq, tracker.next_seq);
    if (tracker.mismatches == 0 && tracker.expected_window_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", tracker.mismatches,
               tracker.expected_window_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/srsw_pkg.sv
hw/rtl/srsw_slot_mod.sv
hw/rtl/srsw_pay_mem.sv
hw/rtl/selective_repeat_sender_window_top.sv
sim/selective_repeat_sender_window_top_tb.sv
